FILE: rtl/assert_macros.svh
// Assertion macros shared by the biquad filter RTL.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

FILE: rtl/csbq_pkg.sv
// Shared types, constants and arithmetic helpers for the shelf biquad filter.
// No dependencies.
package csbq_pkg;

   localparam int SampleW        = 24;
   localparam int CoefW          = 21;
   localparam int GainW          = 18;
   localparam int StateW         = 40;
   localparam int ProdW          = SampleW + CoefW;
   localparam int DiffW          = ProdW + 1;
   localparam int RndShift       = 16;
   localparam int RndW           = DiffW - RndShift;
   localparam int SumW           = StateW + 1;
   localparam int ModeW          = 2;
   localparam int BRegW          = 3 * CoefW;
   localparam int ARegW          = 2 * CoefW;
   localparam int CsrIdxW        = 3;
   localparam int CsrDataW       = BRegW;
   localparam int DefNumChannels = 2;

   localparam logic [ModeW-1:0] MODE_BYPASS = 2'd0;
   localparam logic [ModeW-1:0] MODE_LOW    = 2'd1;
   localparam logic [ModeW-1:0] MODE_HIGH   = 2'd2;
   localparam logic [ModeW-1:0] MODE_BOTH   = 2'd3;

   localparam logic [BRegW-1:0]        BRegReset = BRegW'(65536);
   localparam logic [ARegW-1:0]        ARegReset = '0;
   localparam logic signed [GainW-1:0] GainReset = GainW'(65536);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MODE, CSR_LOW_B, CSR_LOW_A, CSR_HIGH_B, CSR_HIGH_A, CSR_GAIN
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_B0, ST_B1, ST_A1, ST_B2, ST_A2, ST_WB, ST_GAIN, ST_OUT
   } fsm_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_Y, OP_LOAD, OP_S1, OP_WB
   } op_type;

   typedef enum logic [2:0] {
      CF_B0, CF_B1, CF_B2, CF_A1, CF_A2, CF_GAIN
   } coef_type;

   typedef enum logic {
      SEC_LOW, SEC_HIGH
   } sec_type;

   typedef struct packed {
      op_type   op;
      coef_type coef;
      logic     use_y;
      sec_type  sec;
   } dp_ctrl_type;

   function automatic int chan_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // round half up, drop 16 fraction bits
   function automatic logic signed [RndW-1:0] rnd16(input logic signed [DiffW-1:0] v);
      logic signed [DiffW-1:0] t;
      begin
         t = v + DiffW'(32768);
         return t[DiffW-1:RndShift];
      end
   endfunction

   function automatic logic signed [SampleW-1:0] sat_sample(input logic signed [SumW-1:0] v);
      logic [SumW-SampleW:0] hi_bits;
      begin
         hi_bits = v[SumW-1:SampleW-1];
         if (&hi_bits || ~|hi_bits) begin
            return v[SampleW-1:0];
         end else if (v[SumW-1]) begin
            return {1'b1, {(SampleW-1){1'b0}}};
         end else begin
            return {1'b0, {(SampleW-1){1'b1}}};
         end
      end
   endfunction

   function automatic logic signed [StateW-1:0] sat_state(input logic signed [SumW-1:0] v);
      begin
         if (v[SumW-1] == v[SumW-2]) begin
            return v[StateW-1:0];
         end else if (v[SumW-1]) begin
            return {1'b1, {(StateW-1){1'b0}}};
         end else begin
            return {1'b0, {(StateW-1){1'b1}}};
         end
      end
   endfunction

endpackage

FILE: rtl/csbq_if.sv
// Valid/ready channel interfaces: sample request, filtered response, register write.
// Depends on csbq_pkg.
interface csbq_req_if import csbq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      channel;
   logic signed [SampleW-1:0] sample_in;

   modport source (output valid, channel, sample_in, input ready);
   modport sink   (input valid, channel, sample_in, output ready);
endinterface

interface csbq_rsp_if import csbq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      out_channel;
   logic signed [SampleW-1:0] sample_out;

   modport source (output valid, out_channel, sample_out, input ready);
   modport sink   (input valid, out_channel, sample_out, output ready);
endinterface

interface csbq_csr_if import csbq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/csbq_state_mem.sv
// Per-channel section state memory (s1, s2), registered read.
// Depends on csbq_pkg and assert_macros.svh; valid bits make unwritten entries read zero.
`include "assert_macros.svh"
module csbq_state_mem import csbq_pkg::*; #(
   parameter int NUM_CHANNELS = DefNumChannels
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic                           wr_en,
   input  logic [chan_width(NUM_CHANNELS):0] addr,
   input  logic signed [StateW-1:0]       wr_s1,
   input  logic signed [StateW-1:0]       wr_s2,
   output logic signed [StateW-1:0]       rd_s1,
   output logic signed [StateW-1:0]       rd_s2
);

   localparam int AddrW = chan_width(NUM_CHANNELS) + 1;
   localparam int Depth = 1 << AddrW;

   logic [2*StateW-1:0] state_mem [Depth];
   logic [2*StateW-1:0] rdata_ff;
   logic                rvalid_ff;
   logic                rvalid_in;
   logic [Depth-1:0]    valid_ff;
   logic [Depth-1:0]    valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[addr] = 1'b1;
      end
   end

   assign rvalid_in = rd_en ? valid_ff[addr] : rvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[addr] <= {wr_s1, wr_s2};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= state_mem[addr];
      end
   end

   assign rd_s1 = rvalid_ff ? rdata_ff[2*StateW-1:StateW] : '0;
   assign rd_s2 = rvalid_ff ? rdata_ff[StateW-1:0]        : '0;

   `ASSERT_NEVER(a_no_rd_wr_overlap, clock, reset, rd_en && wr_en, "read and write overlap")
   `ASSERT_PROP(a_valid_after_write, clock, reset, wr_en |=> valid_ff[$past(addr)], "valid bit not set")

endmodule

FILE: rtl/csbq_datapath.sv
// Shared 24x21 multiplier with rounding, accumulate and saturation for both sections.
// Depends on csbq_pkg; sequenced by csbq_ctrl.
module csbq_datapath import csbq_pkg::*; (
   input  logic                       clock,
   input  logic                       load_x,
   input  logic signed [SampleW-1:0]  sample_in,
   input  dp_ctrl_type                dp,
   input  logic [BRegW-1:0]           low_b,
   input  logic [ARegW-1:0]           low_a,
   input  logic [BRegW-1:0]           high_b,
   input  logic [ARegW-1:0]           high_a,
   input  logic signed [GainW-1:0]    gain,
   input  logic signed [StateW-1:0]   s1_rd,
   input  logic signed [StateW-1:0]   s2_rd,
   output logic signed [StateW-1:0]   wr_s1,
   output logic signed [StateW-1:0]   wr_s2,
   output logic signed [SampleW-1:0]  result
);

   logic [BRegW-1:0]          b_reg;
   logic [ARegW-1:0]          a_reg;
   logic signed [CoefW-1:0]   cf;
   logic signed [SampleW-1:0] mul_a;
   logic signed [ProdW-1:0]   prod_in, prod_ff;
   logic signed [ProdW-1:0]   acc_in, acc_ff;
   logic signed [SampleW-1:0] x_in, x_ff;
   logic signed [SampleW-1:0] y_in, y_ff;
   logic signed [StateW-1:0]  s1n_in, s1n_ff;
   logic signed [DiffW-1:0]   diff;
   logic signed [RndW-1:0]    rnd_p;
   logic signed [RndW-1:0]    rnd_d;
   logic signed [SumW-1:0]    y_sum;
   logic signed [SumW-1:0]    s1_sum;

   assign b_reg = (dp.sec == SEC_HIGH) ? high_b : low_b;
   assign a_reg = (dp.sec == SEC_HIGH) ? high_a : low_a;

   always_comb begin
      unique case (dp.coef)
         CF_B0:   cf = $signed(b_reg[CoefW-1:0]);
         CF_B1:   cf = $signed(b_reg[2*CoefW-1:CoefW]);
         CF_B2:   cf = $signed(b_reg[3*CoefW-1:2*CoefW]);
         CF_A1:   cf = $signed(a_reg[CoefW-1:0]);
         CF_A2:   cf = $signed(a_reg[2*CoefW-1:CoefW]);
         CF_GAIN: cf = CoefW'(gain);
         default: cf = '0;
      endcase
   end

   assign mul_a   = dp.use_y ? y_ff : x_ff;
   assign prod_in = ProdW'(mul_a) * ProdW'(cf);

   assign diff   = DiffW'(acc_ff) - DiffW'(prod_ff);
   assign rnd_p  = rnd16(DiffW'(prod_ff));
   assign rnd_d  = rnd16(diff);
   assign y_sum  = SumW'(rnd_p) + SumW'(s1_rd);
   assign s1_sum = SumW'(rnd_d) + SumW'(s2_rd);

   assign x_in   = load_x ? sample_in : ((dp.op == OP_WB) ? y_ff : x_ff);
   assign y_in   = (dp.op == OP_Y)    ? sat_sample(y_sum) : y_ff;
   assign acc_in = (dp.op == OP_LOAD) ? prod_ff : acc_ff;
   assign s1n_in = (dp.op == OP_S1)   ? sat_state(s1_sum) : s1n_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      s1n_ff  <= s1n_in;
   end

   // s2 update cannot exceed 30 bits, so no clamp is needed
   assign wr_s1  = s1n_ff;
   assign wr_s2  = StateW'(rnd_d);
   assign result = sat_sample(SumW'(rnd_p));

endmodule

FILE: rtl/csbq_ctrl.sv
// Sequencer: state read, five multiplies per section, write-back, then gain.
// Depends on csbq_pkg.
module csbq_ctrl import csbq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [ModeW-1:0]   mode,
   input  logic               rsp_hold,
   output logic               req_ready,
   output logic               load_x,
   output logic               mem_rd,
   output logic               mem_wr,
   output logic               out_load,
   output dp_ctrl_type        dp
);

   fsm_type state_ff, state_in;
   sec_type sec_ff, sec_in;
   logic    low_sel;
   logic    high_sel;

   assign low_sel  = (mode == MODE_LOW)  || (mode == MODE_BOTH);
   assign high_sel = (mode == MODE_HIGH) || (mode == MODE_BOTH);

   always_comb begin
      state_in = state_ff;
      sec_in   = sec_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (low_sel) begin
                  state_in = ST_READ;
                  sec_in   = SEC_LOW;
               end else if (high_sel) begin
                  state_in = ST_READ;
                  sec_in   = SEC_HIGH;
               end else begin
                  state_in = ST_GAIN;
               end
            end
         end
         ST_READ: state_in = ST_B0;
         ST_B0:   state_in = ST_B1;
         ST_B1:   state_in = ST_A1;
         ST_A1:   state_in = ST_B2;
         ST_B2:   state_in = ST_A2;
         ST_A2:   state_in = ST_WB;
         ST_WB: begin
            if (sec_ff == SEC_LOW && high_sel) begin
               state_in = ST_READ;
               sec_in   = SEC_HIGH;
            end else begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: state_in = ST_OUT;
         ST_OUT:  state_in = rsp_hold ? ST_OUT : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mem_rd    = 1'b0;
      mem_wr    = 1'b0;
      out_load  = 1'b0;
      dp.op     = OP_NONE;
      dp.coef   = CF_GAIN;
      dp.use_y  = 1'b0;
      dp.sec    = sec_ff;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_READ: mem_rd = 1'b1;
         ST_B0:   dp.coef = CF_B0;
         ST_B1: begin
            dp.coef = CF_B1;
            dp.op   = OP_Y;
         end
         ST_A1: begin
            dp.coef  = CF_A1;
            dp.use_y = 1'b1;
            dp.op    = OP_LOAD;
         end
         ST_B2: begin
            dp.coef = CF_B2;
            dp.op   = OP_S1;
         end
         ST_A2: begin
            dp.coef  = CF_A2;
            dp.use_y = 1'b1;
            dp.op    = OP_LOAD;
         end
         ST_WB: begin
            dp.op  = OP_WB;
            mem_wr = 1'b1;
         end
         ST_GAIN: dp.coef = CF_GAIN;
         ST_OUT:  out_load = !rsp_hold;
         default: req_ready = 1'b0;
      endcase
   end

   assign load_x = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sec_ff   <= SEC_LOW;
      end else begin
         state_ff <= state_in;
         sec_ff   <= sec_in;
      end
   end

endmodule

FILE: rtl/cascaded_shelf_biquad_filter.sv
// Top level of the cascaded low/high shelf biquad filter with output gain.
// Depends on csbq_pkg, csbq_if, csbq_ctrl, csbq_datapath, csbq_state_mem.
//
// req_chan carries one sample and its channel per transaction; rsp_chan returns
// the filtered, gain-scaled, saturated sample with the channel echoed. csr_chan
// writes registers: 0 mode, 1/2 low shelf b/a, 3/4 high shelf b/a, 5 gain; it
// is always ready and must only be used while no sample is in flight.
// One item is worked at a time on a single shared multiplier; each section
// reads its two state words from the state memory, runs five multiplies and
// writes back, then one multiply applies the gain.
// The result is registered as the sequencer leaves its output state for idle;
// the next request can be taken in the cycle after that, so a new sample is
// only taken once the result of the previous one is registered.
// Reset clears the registers to their defaults and marks all state entries
// empty, so the filter state reads zero; no clearing pass is needed.
// The result sits in an output register: if the receiver stalls, one result
// waits there while the next sample is already taken and filtered; that next
// item then holds after its gain step, with no new request taken, until the
// register frees.
`include "assert_macros.svh"
module cascaded_shelf_biquad_filter import csbq_pkg::*; #(
   parameter int NUM_CHANNELS = DefNumChannels
) (
   input  logic      clock,
   input  logic      reset,
   csbq_req_if.sink   req_chan,
   csbq_rsp_if.source rsp_chan,
   csbq_csr_if.sink   csr_chan
);

   localparam int ChanW = chan_width(NUM_CHANNELS);
   localparam int AddrW = ChanW + 1;

   logic [ModeW-1:0]          mode_ff, mode_in;
   logic [BRegW-1:0]          low_b_ff, low_b_in;
   logic [ARegW-1:0]          low_a_ff, low_a_in;
   logic [BRegW-1:0]          high_b_ff, high_b_in;
   logic [ARegW-1:0]          high_a_ff, high_a_in;
   logic signed [GainW-1:0]   gain_ff, gain_in;
   logic [ChanW-1:0]          idx_ff, idx_in;
   logic                      ch_ff, ch_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_ch_ff, rsp_ch_in;
   logic signed [SampleW-1:0] rsp_sample_ff, rsp_sample_in;

   logic                      req_fire;
   logic                      csr_fire;
   logic                      rsp_hold;
   logic                      load_x;
   logic                      mem_rd;
   logic                      mem_wr;
   logic                      out_load;
   logic                      req_ready;
   dp_ctrl_type               dp;
   logic [AddrW-1:0]          mem_addr;
   logic signed [StateW-1:0]  s1_rd, s2_rd;
   logic signed [StateW-1:0]  wr_s1, wr_s2;
   logic signed [SampleW-1:0] result;

   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid && req_ready;
   assign rsp_hold       = rsp_valid_ff && !rsp_chan.ready;

   always_comb begin
      mode_in   = mode_ff;
      low_b_in  = low_b_ff;
      low_a_in  = low_a_ff;
      high_b_in = high_b_ff;
      high_a_in = high_a_ff;
      gain_in   = gain_ff;
      if (csr_fire) begin
         unique case (csr_idx_type'(csr_chan.index))
            CSR_MODE:   mode_in   = csr_chan.data[ModeW-1:0];
            CSR_LOW_B:  low_b_in  = csr_chan.data[BRegW-1:0];
            CSR_LOW_A:  low_a_in  = csr_chan.data[ARegW-1:0];
            CSR_HIGH_B: high_b_in = csr_chan.data[BRegW-1:0];
            CSR_HIGH_A: high_a_in = csr_chan.data[ARegW-1:0];
            CSR_GAIN:   gain_in   = $signed(csr_chan.data[GainW-1:0]);
            default:    mode_in   = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BYPASS;
         low_b_ff  <= BRegReset;
         low_a_ff  <= ARegReset;
         high_b_ff <= BRegReset;
         high_a_ff <= ARegReset;
         gain_ff   <= GainReset;
      end else begin
         mode_ff   <= mode_in;
         low_b_ff  <= low_b_in;
         low_a_ff  <= low_a_in;
         high_b_ff <= high_b_in;
         high_a_ff <= high_a_in;
         gain_ff   <= gain_in;
      end
   end

   // out-of-range channels share the last state set
   always_comb begin
      idx_in = idx_ff;
      ch_in  = ch_ff;
      if (req_fire) begin
         ch_in = req_chan.channel;
         if (int'(req_chan.channel) >= NUM_CHANNELS) begin
            idx_in = ChanW'(NUM_CHANNELS - 1);
         end else begin
            idx_in = ChanW'(req_chan.channel);
         end
      end
   end

   assign rsp_valid_in  = out_load || rsp_hold;
   assign rsp_ch_in     = out_load ? ch_ff  : rsp_ch_ff;
   assign rsp_sample_in = out_load ? result : rsp_sample_ff;

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      ch_ff         <= ch_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_channel = rsp_ch_ff;
   assign rsp_chan.sample_out  = rsp_sample_ff;

   assign mem_addr = {dp.sec, idx_ff};

   csbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .mode      (mode_ff),
      .rsp_hold  (rsp_hold),
      .req_ready (req_ready),
      .load_x    (load_x),
      .mem_rd    (mem_rd),
      .mem_wr    (mem_wr),
      .out_load  (out_load),
      .dp        (dp)
   );

   csbq_datapath u_datapath (
      .clock     (clock),
      .load_x    (load_x),
      .sample_in (req_chan.sample_in),
      .dp        (dp),
      .low_b     (low_b_ff),
      .low_a     (low_a_ff),
      .high_b    (high_b_ff),
      .high_a    (high_a_ff),
      .gain      (gain_ff),
      .s1_rd     (s1_rd),
      .s2_rd     (s2_rd),
      .wr_s1     (wr_s1),
      .wr_s2     (wr_s2),
      .result    (result)
   );

   csbq_state_mem #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_state_mem (
      .clock (clock),
      .reset (reset),
      .rd_en (mem_rd),
      .wr_en (mem_wr),
      .addr  (mem_addr),
      .wr_s1 (wr_s1),
      .wr_s2 (wr_s2),
      .rd_s1 (s1_rd),
      .rd_s2 (s2_rd)
   );

   `ASSERT_NEVER(a_rsp_no_overwrite, clock, reset, out_load && rsp_hold, "pending response overwritten")
   `ASSERT_PROP(a_busy_after_accept, clock, reset, req_fire |=> !req_chan.ready, "ready after accept")

endmodule

FILE: sim/tb.sv
// Testbench for cascaded_shelf_biquad_filter: directed and random samples through bypass,
// single and cascaded shelf sections, checked against an in-bench fixed-point predictor.
// Depends on csbq_pkg, csbq_if and the filter RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import csbq_pkg::*;

   localparam int     CycleLimit  = 400000;
   localparam int     DrainCycles = 24;
   localparam int     MaxWait     = 13;
   localparam int     ReportMax   = 10;
   localparam int     GainUnity   = 65536;
   localparam int     CoefMax     = (1 << (CoefW - 1)) - 1;
   localparam int     CoefMin     = -(1 << (CoefW - 1));
   localparam int     GainMax     = (1 << (GainW - 1)) - 1;
   localparam int     GainMin     = -(1 << (GainW - 1));
   localparam longint SampleMax   = (longint'(1) << (SampleW - 1)) - 1;
   localparam longint SampleMin   = -SampleMax - 1;
   localparam longint StateMax    = (longint'(1) << (StateW - 1)) - 1;
   localparam longint StateMin    = -StateMax - 1;

   typedef struct {
      logic                      ch;
      logic signed [SampleW-1:0] value;
   } filtered_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csbq_req_if req_chan ();
   csbq_rsp_if rsp_chan ();
   csbq_csr_if csr_chan ();

   cascaded_shelf_biquad_filter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of registers and filter state
   logic [ModeW-1:0]         mdl_mode   = MODE_BYPASS;
   logic [BRegW-1:0]         mdl_low_b  = BRegReset;
   logic [ARegW-1:0]         mdl_low_a  = ARegReset;
   logic [BRegW-1:0]         mdl_high_b = BRegReset;
   logic [ARegW-1:0]         mdl_high_a = ARegReset;
   logic signed [GainW-1:0]  mdl_gain   = GainReset;
   logic signed [StateW-1:0] low_s1  [DefNumChannels] = '{default: '0};
   logic signed [StateW-1:0] low_s2  [DefNumChannels] = '{default: '0};
   logic signed [StateW-1:0] high_s1 [DefNumChannels] = '{default: '0};
   logic signed [StateW-1:0] high_s2 [DefNumChannels] = '{default: '0};

   filtered_type expected_out[$];
   int           errors      = 0;
   int           cycle_count = 0;
   bit           gapless     = 1'b0;
   int           hold_off    = 0;

   function automatic logic [63:0] wide_rand();
      return {$urandom, $urandom};
   endfunction

   function automatic longint drop16(input longint p);
      return (p + 32768) >>> 16;
   endfunction

   function automatic logic signed [SampleW-1:0] clip_sample(input longint v);
      return SampleW'(v < SampleMin ? SampleMin : (v > SampleMax ? SampleMax : v));
   endfunction

   function automatic logic signed [StateW-1:0] clip_state(input longint v);
      return StateW'(v < StateMin ? StateMin : (v > StateMax ? StateMax : v));
   endfunction

   function automatic void store_reg(input logic [CsrIdxW-1:0] idx,
                                     input logic [CsrDataW-1:0] data);
      case (idx)
         CSR_MODE:   mdl_mode   = data[ModeW-1:0];
         CSR_LOW_B:  mdl_low_b  = data[BRegW-1:0];
         CSR_LOW_A:  mdl_low_a  = data[ARegW-1:0];
         CSR_HIGH_B: mdl_high_b = data[BRegW-1:0];
         CSR_HIGH_A: mdl_high_a = data[ARegW-1:0];
         CSR_GAIN:   mdl_gain   = data[GainW-1:0];
         default: ;
      endcase
   endfunction

   // transposed direct form II; x becomes the section output
   task automatic run_section(input logic [BRegW-1:0] b, input logic [ARegW-1:0] a,
                              inout logic signed [SampleW-1:0] x,
                              inout logic signed [StateW-1:0] s1,
                              inout logic signed [StateW-1:0] s2);
      logic signed [CoefW-1:0]   b0, b1, b2, a1, a2;
      logic signed [SampleW-1:0] y;
      b0 = b[CoefW-1:0];
      b1 = b[2*CoefW-1:CoefW];
      b2 = b[3*CoefW-1:2*CoefW];
      a1 = a[CoefW-1:0];
      a2 = a[2*CoefW-1:CoefW];
      y  = clip_sample(drop16(longint'(b0) * longint'(x)) + longint'(s1));
      s1 = clip_state(drop16(longint'(b1) * longint'(x) - longint'(a1) * longint'(y))
                      + longint'(s2));
      s2 = clip_state(drop16(longint'(b2) * longint'(x) - longint'(a2) * longint'(y)));
      x  = y;
   endtask

   task automatic predict_sample(input logic ch, input logic signed [SampleW-1:0] x);
      int                        idx;
      logic signed [SampleW-1:0] y;
      filtered_type              item;
      idx = (int'(ch) < DefNumChannels) ? int'(ch) : DefNumChannels - 1;
      y   = x;
      if (mdl_mode == MODE_LOW || mdl_mode == MODE_BOTH) begin
         run_section(mdl_low_b, mdl_low_a, y, low_s1[idx], low_s2[idx]);
      end
      if (mdl_mode == MODE_HIGH || mdl_mode == MODE_BOTH) begin
         run_section(mdl_high_b, mdl_high_a, y, high_s1[idx], high_s2[idx]);
      end
      item.ch    = ch;
      item.value = clip_sample(drop16(longint'(y) * longint'(mdl_gain)));
      expected_out.push_back(item);
   endtask

   task automatic send_sample(input logic ch, input logic signed [SampleW-1:0] x);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, MaxWait);
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.channel   <= ch;
      req_chan.sample_in <= x;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_sample(ch, x);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      store_reg(idx, data);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic write_mode(input logic [ModeW-1:0] mode);
      logic [CsrDataW-1:0] w;
      w = CsrDataW'(wide_rand());
      w[ModeW-1:0] = mode;
      write_reg(CSR_MODE, w);
   endtask

   // stop offering samples and wait until every response is back
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_out.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [BRegW-1:0] pack_b(input int b0, input int b1, input int b2);
      return {CoefW'(b2), CoefW'(b1), CoefW'(b0)};
   endfunction

   function automatic logic [ARegW-1:0] pack_a(input int a1, input int a2);
      return {CoefW'(a2), CoefW'(a1)};
   endfunction

   // one draw in five is random; else feedback sits inside the stability triangle
   function automatic logic [ARegW-1:0] stable_a();
      int a1, a2, lim;
      if ($urandom_range(0, 4) == 0) return ARegW'(wide_rand());
      a2  = $urandom_range(0, 120000) - 60000;
      lim = GainUnity + a2 - 2000;
      a1  = $urandom_range(0, 2 * lim) - lim;
      return pack_a(a1, a2);
   endfunction

   function automatic logic [BRegW-1:0] stable_b();
      if ($urandom_range(0, 4) == 0) return BRegW'(wide_rand());
      return pack_b($urandom_range(0, 262144) - 131072, $urandom_range(0, 262144) - 131072,
                    $urandom_range(0, 262144) - 131072);
   endfunction

   function automatic logic signed [SampleW-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return ($urandom_range(0, 1) != 0) ? SampleW'(SampleMax) : SampleW'(SampleMin);
         1, 2: return SampleW'($urandom);
         default: return SampleW'($signed($urandom) >>> $urandom_range(8, 20));
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_sample(1'b0, SampleW'(SampleMax));
      send_sample(1'b1, SampleW'(SampleMin));
      send_sample(1'b0, '0);
      send_sample(1'b1, -24'sd1);
      settle();
   endtask

   task automatic test_gain_extremes();
      int gains[3];
      gains = '{GainMax, GainMin, 0};
      foreach (gains[i]) begin
         write_reg(CSR_GAIN, CsrDataW'(gains[i]));
         send_sample(1'b0, SampleW'(SampleMax));
         send_sample(1'b1, SampleW'(SampleMin));
         settle();
      end
      write_reg(CSR_GAIN, CsrDataW'(GainUnity));
   endtask

   task automatic test_sections();
      logic [ModeW-1:0] modes[3];
      modes = '{MODE_LOW, MODE_HIGH, MODE_BOTH};
      write_reg(CSR_LOW_B, CsrDataW'(pack_b(CoefMax, CoefMin, CoefMax)));
      write_reg(CSR_LOW_A, CsrDataW'(pack_a(CoefMax, CoefMin)));
      write_reg(CSR_HIGH_B, CsrDataW'(pack_b(32768, -65536, 32768)));
      write_reg(CSR_HIGH_A, CsrDataW'(pack_a(-32768, 16384)));
      foreach (modes[i]) begin
         write_mode(modes[i]);
         send_sample(1'b0, SampleW'(SampleMax));
         send_sample(1'b1, SampleW'(SampleMin));
         send_sample(1'b0, 24'sd1234);
         settle();
      end
   endtask

   task automatic test_unused_index();
      for (int i = int'(CSR_GAIN) + 1; i < (1 << CsrIdxW); i++) begin
         write_reg(CsrIdxW'(i), CsrDataW'(wide_rand()));
      end
      send_sample(1'b1, 24'sd4000000);
      send_sample(1'b0, -24'sd4000000);
      settle();
   endtask

   task automatic load_random_setup();
      logic [CsrDataW-1:0] g;
      write_mode(ModeW'($urandom_range(MODE_BYPASS, MODE_BOTH)));
      write_reg(CSR_LOW_B, CsrDataW'(stable_b()));
      write_reg(CSR_LOW_A, CsrDataW'(stable_a()));
      write_reg(CSR_HIGH_B, CsrDataW'(stable_b()));
      write_reg(CSR_HIGH_A, CsrDataW'(stable_a()));
      if ($urandom_range(0, 3) == 0) g = CsrDataW'(wide_rand());
      else g = CsrDataW'(GainUnity + $urandom_range(0, 32768) - 16384);
      write_reg(CSR_GAIN, g);
   endtask

   task automatic test_random_phases(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         load_random_setup();
         gapless = (p % 4 == 3);
         for (int i = 0; i < per_phase; i++) begin
            if (p == 2 && i == per_phase / 2) settle();
            send_sample(1'($urandom), rand_sample());
         end
         gapless = 1'b0;
         settle();
      end
   endtask

   task automatic test_backpressure();
      load_random_setup();
      write_mode(MODE_BOTH);
      hold_off = 400;
      gapless  = 1'b1;
      repeat (40) send_sample(1'($urandom), rand_sample());
      gapless  = 1'b0;
      settle();
   endtask

   // response side: random stalls per transaction, long hold-off on request
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = gapless ? 0 : $urandom_range(0, MaxWait);
         if (hold_off != 0) begin
            stall    = hold_off;
            hold_off = 0;
         end
         @(negedge clock);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      filtered_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_out.size() == 0) begin
            if (errors < ReportMax) begin
               $display("unexpected response: ch %0d sample %0d",
                        rsp_chan.out_channel, rsp_chan.sample_out);
            end
            errors++;
         end else begin
            want = expected_out.pop_front();
            if (rsp_chan.out_channel !== want.ch || rsp_chan.sample_out !== want.value) begin
               if (errors < ReportMax) begin
                  $display("bad response: expected ch %0d sample %0d, got ch %0d sample %0d",
                           want.ch, want.value, rsp_chan.out_channel, rsp_chan.sample_out);
               end
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("cascaded_shelf_biquad_filter: mismatch");
         $finish;
      end
   end

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.channel   = 1'b0;
      req_chan.sample_in = '0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = '0;
      csr_chan.data      = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_gain_extremes();
      test_sections();
      test_unused_index();
      test_random_phases(10, 105);
      test_backpressure();
      settle();
      if (errors == 0 && expected_out.size() == 0) begin
         $display("cascaded_shelf_biquad_filter: match");
      end else begin
         $display("cascaded_shelf_biquad_filter: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/csbq_pkg.sv
rtl/csbq_if.sv
rtl/csbq_state_mem.sv
rtl/csbq_datapath.sv
rtl/csbq_ctrl.sv
rtl/cascaded_shelf_biquad_filter.sv
sim/tb.sv
